[hw/rtl/fta_pkg.sv]
// fta_pkg: shared constants, types and state codes for the frame time averager
// used by fta_ring, fta_scan, fta_div and frame_time_average_and_jitter
package fta_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int DATA_W       = 32;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = DATA_W + SLOT_W;
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int ADDR_W       = 3;

  localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd16666667;
  localparam logic              REG_VALID_LIMIT = 1'b0;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } ring_rd_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  sum;
    logic [DATA_W-1:0] rise;
  } scan_res_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

[hw/rtl/frame_time_average_and_jitter.sv]
// frame_time_average_and_jitter: top level, control sequencer, APB register
// depends on fta_pkg, fta_ring, fta_scan, fta_div
//
// Each input beat carries one frame time in ticks. A sample of zero or one
// above valid_limit is discarded and leaves the state alone; its result beat
// has accepted low and repeats the last average and rise. A stored sample goes
// into the 16-entry ring and the result beat carries the truncated mean of the
// filled entries and the largest rise between neighbouring entries.
// One beat is taken at a time. A discarded sample goes straight to the output
// register; a stored one first passes the ring scan at one entry per cycle and
// the restoring divider at one quotient bit per cycle over a 36-bit sum.
// valid_limit is written through the APB port at address 0 (only paddr[2] is
// decoded, so 1 to 3 mirror it) and resets to 16666667; pready is always high.
// Reset clears the fill count, write slot, last average and rise and all
// handshake state; ring contents stay as they are, only written entries are read.
// When the receiver stalls the result waits in the output register and the
// block holds its finished work and takes no new beat until it drains.
module frame_time_average_and_jitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fta_pkg::DATA_W-1:0]     frame_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic [fta_pkg::DATA_W-1:0]     average_time,
  output logic [fta_pkg::DATA_W-1:0]     max_rise,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fta_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  fta_pkg::state_t             state;
  fta_pkg::state_t             state_next;
  logic [fta_pkg::DATA_W-1:0]  valid_limit;
  logic [fta_pkg::DATA_W-1:0]  sample;
  logic [fta_pkg::SLOT_W-1:0]  write_slot;
  logic [fta_pkg::CNT_W-1:0]   fill_count;
  logic [fta_pkg::CNT_W-1:0]   fill_next;
  logic [fta_pkg::DATA_W-1:0]  last_average;
  logic [fta_pkg::DATA_W-1:0]  last_rise;
  logic                        res_acc;
  logic                        sample_ok;
  logic                        store;
  logic                        reg_hit;

  fta_pkg::ring_rd_t           rd;
  logic [fta_pkg::DATA_W-1:0]  rdata;
  fta_pkg::scan_res_t          scan_res;
  fta_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [fta_pkg::DATA_W-1:0]  quotient;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[fta_pkg::ADDR_W-1] == fta_pkg::REG_VALID_LIMIT);
  assign prdata   = reg_hit ? valid_limit : '0;
  assign in_ready = (state == fta_pkg::ST_IDLE);

  assign sample_ok = (sample != '0) && (sample <= valid_limit);
  assign store     = (state == fta_pkg::ST_CHECK) && sample_ok;
  assign fill_next = (fill_count < fta_pkg::CNT_W'(fta_pkg::WINDOW_DEPTH))
                     ? fill_count + fta_pkg::CNT_W'(1) : fill_count;

  assign div_req.start    = (state == fta_pkg::ST_SCAN) && scan_res.done;
  assign div_req.dividend = scan_res.sum;
  assign div_req.divisor  = fill_count;

  fta_ring u_ring (
    .clk   (clk),
    .we    (store),
    .waddr (write_slot),
    .wdata (sample),
    .rd    (rd),
    .rdata (rdata)
  );

  fta_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (store),
    .fill  (fill_next),
    .rd    (rd),
    .rdata (rdata),
    .res   (scan_res)
  );

  fta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      fta_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = fta_pkg::ST_CHECK;
        end
      end
      fta_pkg::ST_CHECK: begin
        state_next = sample_ok ? fta_pkg::ST_SCAN : fta_pkg::ST_DONE;
      end
      fta_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_next = fta_pkg::ST_DIV;
        end
      end
      fta_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = fta_pkg::ST_DONE;
        end
      end
      fta_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = fta_pkg::ST_IDLE;
        end
      end
      default: state_next = fta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fta_pkg::ST_IDLE;
      valid_limit  <= fta_pkg::LIMIT_RESET;
      write_slot   <= '0;
      fill_count   <= '0;
      last_average <= '0;
      last_rise    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && reg_hit) begin
        valid_limit <= pwdata;
      end
      if (store) begin
        fill_count <= fill_next;
        if (write_slot == fta_pkg::SLOT_W'(fta_pkg::WINDOW_DEPTH - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + fta_pkg::SLOT_W'(1);
        end
      end
      if ((state == fta_pkg::ST_DIV) && div_done) begin
        last_average <= quotient;
        last_rise    <= scan_res.rise;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == fta_pkg::ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= frame_time;
    end
    if (state == fta_pkg::ST_CHECK) begin
      res_acc <= sample_ok;
    end
    if ((state == fta_pkg::ST_DONE) && (!out_valid || out_ready)) begin
      accepted     <= res_acc;
      average_time <= last_average;
      max_rise     <= last_rise;
    end
  end

endmodule

[hw/rtl/fta_ring.sv]
// fta_ring: sample ring storage, one write port and one registered read port
// depends on fta_pkg
module fta_ring (
  input  logic                           clk,
  input  logic                           we,
  input  logic [fta_pkg::SLOT_W-1:0]     waddr,
  input  logic [fta_pkg::DATA_W-1:0]     wdata,
  input  fta_pkg::ring_rd_t              rd,
  output logic [fta_pkg::DATA_W-1:0]     rdata
);

  logic [fta_pkg::DATA_W-1:0] mem [fta_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

[hw/rtl/fta_scan.sv]
// fta_scan: walks the filled ring entries one per cycle, sums them and tracks
// the largest rise between neighbours; depends on fta_pkg
module fta_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fta_pkg::CNT_W-1:0]      fill,
  output fta_pkg::ring_rd_t              rd,
  input  logic [fta_pkg::DATA_W-1:0]     rdata,
  output fta_pkg::scan_res_t             res
);

  logic                        busy;
  logic [fta_pkg::CNT_W-1:0]   idx;
  logic [fta_pkg::CNT_W-1:0]   limit;
  logic                        data_vld;
  logic                        first;
  logic [fta_pkg::DATA_W-1:0]  prev;
  logic [fta_pkg::SUM_W-1:0]   sum;
  logic [fta_pkg::DATA_W-1:0]  rise;
  logic [fta_pkg::DATA_W-1:0]  diff;
  logic                        issue;

  assign issue   = busy && (idx < limit);
  assign rd.en   = issue;
  assign rd.addr = idx[fta_pkg::SLOT_W-1:0];
  assign diff    = rdata - prev;

  assign res.done = busy && !issue && !data_vld;
  assign res.sum  = sum;
  assign res.rise = rise;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      data_vld <= 1'b0;
      idx      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      data_vld <= 1'b0;
      idx      <= '0;
    end else begin
      data_vld <= issue;
      if (issue) begin
        idx <= idx + fta_pkg::CNT_W'(1);
      end
      if (res.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      limit <= fill;
      sum   <= '0;
      rise  <= '0;
      first <= 1'b1;
    end else begin
      if (issue) begin
        first <= (idx == '0);
      end
      if (data_vld) begin
        sum  <= sum + fta_pkg::SUM_W'(rdata);
        prev <= rdata;
        if (!first && (rdata > prev) && (diff > rise)) begin
          rise <= diff;
        end
      end
    end
  end

endmodule

[hw/rtl/fta_div.sv]
// fta_div: restoring divider, one quotient bit per cycle through a shift register
// depends on fta_pkg
module fta_div (
  input  logic                           clk,
  input  logic                           rst,
  input  fta_pkg::div_req_t              req,
  output logic                           done,
  output logic [fta_pkg::DATA_W-1:0]     quotient
);

  logic                        busy;
  logic [fta_pkg::STEP_W-1:0]  step;
  logic [fta_pkg::SUM_W-1:0]   quo;
  logic [fta_pkg::CNT_W-1:0]   rem;
  logic [fta_pkg::CNT_W-1:0]   dvs;
  logic [fta_pkg::CNT_W:0]     trial;
  logic                        qbit;

  assign trial    = {rem, quo[fta_pkg::SUM_W-1]};
  assign qbit     = trial >= {1'b0, dvs};
  assign quotient = quo[fta_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= fta_pkg::STEP_W'(fta_pkg::SUM_W - 1);
      end else if (busy) begin
        step <= step - fta_pkg::STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[fta_pkg::SUM_W-2:0], qbit};
      if (qbit) begin
        rem <= fta_pkg::CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[fta_pkg::CNT_W-1:0];
      end
    end
  end

endmodule
